// File: src/lcdseq_pkg.sv
// Shared types, codes and constant tables for the character LCD nibble sequencer.
package lcdseq_pkg;

    // Request codes
    localparam logic [2:0] OP_INIT  = 3'd0;
    localparam logic [2:0] OP_CLEAR = 3'd1;
    localparam logic [2:0] OP_DATA  = 3'd2;
    localparam logic [2:0] OP_CMD   = 3'd3;
    localparam logic [2:0] OP_POS   = 3'd4;

    localparam logic [7:0]  CLEAR_BYTE    = 8'h01;
    localparam logic [7:0]  POS_FLAG      = 8'h80;
    localparam logic [12:0] BASE_WAIT_US  = 13'd50;
    localparam logic [12:0] CLEAR_WAIT_US = 13'd1550;
    localparam logic [17:0] POWER_UP_US   = 18'd150000;
    localparam int unsigned INIT_STROBES  = 16;
    localparam int unsigned IDX_W         = $clog2(INIT_STROBES);

    localparam logic [7:0] ROW_OFFSET [4] = '{8'h00, 8'h40, 8'h14, 8'h54};

    // Power-up run: 3,3,3,2 then bytes 28, 0C, 01, 06, 02, 80
    localparam logic [3:0] INIT_NIBBLE [INIT_STROBES] = '{
        4'h3, 4'h3, 4'h3, 4'h2,
        4'h2, 4'h8, 4'h0, 4'hC, 4'h0, 4'h1,
        4'h0, 4'h6, 4'h0, 4'h2, 4'h8, 4'h0
    };

    localparam logic [12:0] INIT_WAIT_US [INIT_STROBES] = '{
        13'd4550, 13'd4550, 13'd250, 13'd1050,
        13'd50, 13'd50, 13'd50, 13'd1050, 13'd50, 13'd2050,
        13'd50, 13'd1050, 13'd50, 13'd50, 13'd50, 13'd2050
    };

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] data_byte;
        logic [7:0] column;
        logic [1:0] row;
    } req_t;

    typedef struct packed {
        logic [3:0]  nibble;
        logic        reg_select;
        logic [17:0] wait_before_us;
        logic [12:0] wait_after_us;
        logic        last;
    } strobe_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic emit;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
        logic strobe_last;
    } dp_status_t;

endpackage

// File: src/lcdseq_datapath.sv
// Request registers, strobe counter, strobe generation and output register.
module lcdseq_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lcdseq_pkg::req_t     s_data,
    input  lcdseq_pkg::dp_cmd_t  cmd,
    output lcdseq_pkg::dp_status_t status,
    output logic                 m_valid,
    input  logic                 m_ready,
    output lcdseq_pkg::strobe_t  m_data
);

    logic [2:0]                   op_reg, op_next;
    logic [7:0]                   byte_reg, byte_next;
    logic                         rs_reg, rs_next;
    logic [lcdseq_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic                         m_valid_reg, m_valid_next;
    lcdseq_pkg::strobe_t          m_data_reg, m_data_next;
    lcdseq_pkg::strobe_t          cur_strobe;
    logic [8:0]                   pos_sum;

    // Request registers and strobe counter; byte to send for a request other than initialize
    always_comb begin
        pos_sum = {1'b0, lcdseq_pkg::ROW_OFFSET[s_data.row]} + {1'b0, s_data.column};
        op_next   = op_reg;
        byte_next = byte_reg;
        rs_next   = rs_reg;
        idx_next  = idx_reg;
        if (cmd.load) begin
            op_next  = s_data.opcode;
            rs_next  = (s_data.opcode == lcdseq_pkg::OP_DATA);
            idx_next = '0;
            case (s_data.opcode)
                lcdseq_pkg::OP_CLEAR: byte_next = lcdseq_pkg::CLEAR_BYTE;
                lcdseq_pkg::OP_POS:   byte_next = pos_sum[7:0] | lcdseq_pkg::POS_FLAG;
                default:              byte_next = s_data.data_byte;
            endcase
        end else if (cmd.emit) begin
            idx_next = idx_reg + 1'b1;
        end
    end

    // Strobe for the current position in the run
    always_comb begin
        cur_strobe = '0;
        if (op_reg == lcdseq_pkg::OP_INIT) begin
            cur_strobe.nibble         = lcdseq_pkg::INIT_NIBBLE[idx_reg];
            cur_strobe.reg_select     = 1'b0;
            cur_strobe.wait_before_us = (idx_reg == '0) ? lcdseq_pkg::POWER_UP_US : '0;
            cur_strobe.wait_after_us  = lcdseq_pkg::INIT_WAIT_US[idx_reg];
            cur_strobe.last           = (idx_reg == lcdseq_pkg::IDX_W'(lcdseq_pkg::INIT_STROBES - 1));
        end else begin
            cur_strobe.nibble         = idx_reg[0] ? byte_reg[3:0] : byte_reg[7:4];
            cur_strobe.reg_select     = rs_reg;
            cur_strobe.wait_before_us = '0;
            if (idx_reg[0] && op_reg == lcdseq_pkg::OP_CLEAR) begin
                cur_strobe.wait_after_us = lcdseq_pkg::CLEAR_WAIT_US;
            end else begin
                cur_strobe.wait_after_us = lcdseq_pkg::BASE_WAIT_US;
            end
            cur_strobe.last           = idx_reg[0];
        end
    end

    // Output register: load on emit, drop valid once taken
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (cmd.emit) begin
            m_valid_next = 1'b1;
            m_data_next  = cur_strobe;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        op_reg     <= op_next;
        byte_reg   <= byte_next;
        rs_reg     <= rs_next;
        idx_reg    <= idx_next;
        m_data_reg <= m_data_next;
    end

    assign status.out_free    = !m_valid_reg || m_ready;
    assign status.strobe_last = cur_strobe.last;
    assign m_valid            = m_valid_reg;
    assign m_data             = m_data_reg;

endmodule

// File: src/lcdseq_ctrl.sv
// Controller state machine: accept a request, then step through its strobes.
module lcdseq_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [2:0]             opcode,
    input  lcdseq_pkg::dp_status_t status,
    output lcdseq_pkg::dp_cmd_t    cmd
);

    lcdseq_pkg::state_t state_reg, state_next;
    logic               op_known;

    assign op_known = (opcode <= lcdseq_pkg::OP_POS);

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lcdseq_pkg::ST_IDLE: begin
                if (s_valid && op_known) begin
                    state_next = lcdseq_pkg::ST_RUN;
                end
            end
            lcdseq_pkg::ST_RUN: begin
                if (status.out_free && status.strobe_last) begin
                    state_next = lcdseq_pkg::ST_IDLE;
                end
            end
            default: state_next = lcdseq_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        s_ready  = 1'b0;
        cmd.load = 1'b0;
        cmd.emit = 1'b0;
        unique case (state_reg)
            lcdseq_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid && op_known;
            end
            lcdseq_pkg::ST_RUN: begin
                cmd.emit = status.out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lcdseq_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: src/char_lcd_nibble_command_sequencer.sv
// Top level of the character LCD 4-bit request sequencer.
//
// The input channel (s_valid/s_ready/s_data) takes one request item: initialise,
// clear, write data byte, write command byte or set cursor position. The result
// channel (m_valid/m_ready/m_data) gives one item per enable strobe: the nibble,
// register select, waits before and after in microseconds, and a last marker.
// A byte goes out as two strobes, high nibble first; initialise gives sixteen.
// Undefined request codes are taken and dropped with no result.
// The request is captured in the request registers, and the first strobe is then
// loaded into the output register once that register is free. The strobe counter
// advances whenever the output register is empty or its strobe is being taken;
// the controller handles one request at a time.
// s_ready is high only while the controller is idle, which includes the time
// the final strobe of the previous request still waits in the output register.
// When the receiver stalls, hold the strobe in the output register and stop the
// counter until it is taken. Reset (aresetn low, synchronous) returns the
// controller to idle and empties the output register; no clearing pass is needed.
module char_lcd_nibble_command_sequencer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lcdseq_pkg::req_t    s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output lcdseq_pkg::strobe_t m_data
);

    lcdseq_pkg::dp_cmd_t    cmd;
    lcdseq_pkg::dp_status_t status;

    // Sequence control: request acceptance and strobe stepping
    lcdseq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .opcode  (s_data.opcode),
        .status  (status),
        .cmd     (cmd)
    );

    // Request registers, strobe table lookup and output register
    lcdseq_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
